[hw/rtl/session_sequence_replay_window_top_assert.svh]
// Assertion macros for the session sequence replay window.
// Used by the checker module; needs nothing else.
`ifndef SESSION_SEQUENCE_REPLAY_WINDOW_TOP_ASSERT_SVH
`define SESSION_SEQUENCE_REPLAY_WINDOW_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSRW_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ssrw: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SSRW_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("ssrw: next-cycle check failed");

`endif

[hw/rtl/ssrw_pkg.sv]
// Package for the session sequence replay window.
// Holds widths, reset values and register indexes; depends on nothing.
package ssrw_pkg;

   // Defaults for the top-level parameters.
   localparam int SEQ_WIDTH_DEF  = 32;
   localparam int WINDOW_MAX_DEF = 32;

   // Bitmap of numbers below the highest: bit k-1 stands for distance k.
   localparam int MAP_WIDTH     = 32;
   localparam int MAP_IDX_WIDTH = $clog2(MAP_WIDTH);
   localparam logic [MAP_WIDTH-1:0] MAP_RESET = 32'h0000_00FF;
   localparam logic [MAP_WIDTH-1:0] MAP_ONE   = 32'h0000_0001;

   // Window register.
   localparam int WIN_WIDTH = 6;
   localparam logic [WIN_WIDTH-1:0] DEFAULT_WINDOW = 6'd8;

   // Configuration port.
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 6;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_WINDOW_SIZE   = 2'd0,
      CSR_PROTOCOL_MODE = 2'd1
   } csr_index_type;

endpackage

[hw/rtl/session_sequence_replay_window_top.sv]
// Top level of the session sequence replay window (anti-replay check).
// Depends on ssrw_pkg.
//
// Usage:
//   req_*  : one sequence number per transfer (valid/stall, stall driven here).
//   rsp_*  : one accept/reject result per request, in order (valid/stall).
//   csr_*  : register writes, always ready; index 0 = window size (0 means 8,
//            values above WINDOW_MAX saturate), index 1 = protocol mode
//            (1 = zero is invalid and skipped on wrap). Write only when idle.
// A request accepted is held in the input register, and its result is loaded
// into the result register once that register is free.
// Throughput is one transfer per cycle while no result is stalled: the check
// and the window update are one pass of logic on the highest-seen register
// and the 32-bit bitmap, so each item sees the state left by the one
// before it.
// Stall: when rsp_stall holds a result, the queued request waits in the input
// register and req_stall rises only once both registers are full.
// Reset: highest seen is zero, the bitmap holds its eight low bits set, the
// window is 8 and the mode is version 1.5; both registers are emptied.
module session_sequence_replay_window_top
   import ssrw_pkg::*;
#(
   parameter int SEQ_WIDTH  = SEQ_WIDTH_DEF,
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SEQ_WIDTH-1:0]      req_sequence_number,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_accepted,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data
);

   localparam int DW = SEQ_WIDTH + 1;
   localparam logic [WIN_WIDTH-1:0] WIN_LIMIT = WIN_WIDTH'(WINDOW_MAX);

   // Pipeline registers.
   logic                 in_vld_ff;
   logic [SEQ_WIDTH-1:0] seq_ff;
   logic                 rsp_vld_ff;
   logic                 acc_ff;
   logic                 acc_in;

   // Window state and configuration.
   logic [SEQ_WIDTH-1:0] high_ff, high_in;
   logic [MAP_WIDTH-1:0] map_ff, map_in;
   logic [WIN_WIDTH-1:0] win_ff;
   logic                 mode_ff;

   logic out_load;
   logic advance;
   logic in_load;

   // Handshake: the result register frees when empty or taken.
   assign out_load  = !rsp_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_load;
   assign req_stall = in_vld_ff && !out_load;
   assign in_load   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_accepted = acc_ff;

   // Check logic.
   logic [WIN_WIDTH-1:0] win_eff;
   logic [SEQ_WIDTH-1:0] wx, vx, gap, a_lim, b_lim;
   logic [DW-1:0]        a_dist, b_dist;
   logic                 s_gt_h, s_lt_h, a_wrap, b_wrap, a_hit, b_hit, a_bad, b_ok;
   logic [WIN_WIDTH-1:0] a_dm1, b_dm1;
   logic [MAP_WIDTH-1:0] a_bit, b_bit;

   always_comb begin
      // Effective window: zero selects the default, large values saturate.
      if (win_ff == '0) begin
         win_eff = DEFAULT_WINDOW;
      end else if (win_ff > WIN_LIMIT) begin
         win_eff = WIN_LIMIT;
      end else begin
         win_eff = win_ff;
      end

      wx     = {{(SEQ_WIDTH-WIN_WIDTH){1'b0}}, win_eff};
      vx     = {{(SEQ_WIDTH-1){1'b0}}, mode_ff};
      gap    = ~high_ff;
      s_gt_h = seq_ff > high_ff;
      s_lt_h = seq_ff < high_ff;

      // Distances ahead and behind, counted across the top of the range.
      a_dist = s_gt_h ? ({1'b0, seq_ff} - {1'b0, high_ff})
                      : ({1'b0, seq_ff} + {1'b0, gap} + DW'(!mode_ff));
      b_dist = s_gt_h ? ({1'b0, high_ff} + {1'b0, ~seq_ff} + DW'(!mode_ff))
                      : ({1'b0, high_ff} - {1'b0, seq_ff});

      // Ahead window, with the wrapped case near the top of the range.
      a_wrap = gap < wx;
      a_lim  = wx - gap - {{(SEQ_WIDTH-1){1'b0}}, 1'b1} + vx;
      a_hit  = a_wrap ? (s_gt_h || (seq_ff <= a_lim))
                      : (s_gt_h && (a_dist <= DW'(win_eff)));
      a_bad  = (a_dist == '0) || (a_dist > DW'(MAP_WIDTH));

      // Behind window, with the wrapped case near zero.
      b_wrap = high_ff < wx;
      b_lim  = '0 - (wx - high_ff) - vx;
      b_hit  = b_wrap ? (s_lt_h || (seq_ff >= b_lim))
                      : (s_lt_h && (seq_ff >= (high_ff - wx)));

      a_dm1 = a_dist[WIN_WIDTH-1:0] - WIN_WIDTH'(1);
      b_dm1 = b_dist[WIN_WIDTH-1:0] - WIN_WIDTH'(1);
      a_bit = MAP_ONE << a_dm1[MAP_IDX_WIDTH-1:0];
      b_bit = MAP_ONE << b_dm1[MAP_IDX_WIDTH-1:0];
      b_ok  = (b_dist != '0) && (b_dist <= DW'(MAP_WIDTH)) && ((map_ff & b_bit) == '0);

      acc_in  = 1'b0;
      high_in = high_ff;
      map_in  = map_ff;
      if ((seq_ff == high_ff) || (mode_ff && (seq_ff == '0))) begin
         acc_in = 1'b0;
      end else if (a_hit) begin
         // A number ahead becomes the highest; a shift of 32 clears the map.
         if (!a_bad) begin
            acc_in  = 1'b1;
            high_in = seq_ff;
            map_in  = (map_ff << a_dist[WIN_WIDTH-1:0]) | a_bit;
         end
      end else if (b_hit && b_ok) begin
         acc_in = 1'b1;
         map_in = map_ff | b_bit;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         high_ff    <= '0;
         map_ff     <= MAP_RESET;
         win_ff     <= DEFAULT_WINDOW;
         mode_ff    <= 1'b0;
      end else begin
         if (in_load) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_vld_ff <= in_vld_ff;
         end
         if (advance) begin
            high_ff <= high_in;
            map_ff  <= map_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_SIZE:   win_ff  <= csr_data[WIN_WIDTH-1:0];
               CSR_PROTOCOL_MODE: mode_ff <= csr_data[0];
               default:           ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (in_load) begin
         seq_ff <= req_sequence_number;
      end
      if (advance) begin
         acc_ff <= acc_in;
      end
   end

endmodule

[hw/rtl/ssrw_checker.sv]
// Port-level checker for the session sequence replay window, with its bind.
// Depends on ssrw_pkg and session_sequence_replay_window_top_assert.svh.
`include "session_sequence_replay_window_top_assert.svh"

module ssrw_checker
   import ssrw_pkg::*;
#(
   parameter int SEQ_WIDTH = SEQ_WIDTH_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic [SEQ_WIDTH-1:0]      req_sequence_number,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_accepted,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input logic [CSR_DATA_WIDTH-1:0] csr_data
);

   // Requests taken but not yet answered.
   logic [1:0] pend_ff;
   logic       req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + {1'b0, req_take} - {1'b0, rsp_take};
      end
   end

   // No result appears without a request waiting for it.
   `SSRW_ASSERT_NOW(a_no_spurious_rsp, clock, reset, rsp_valid, pend_ff != 2'd0)
   // Requests are held back only while both registers are occupied.
   `SSRW_ASSERT_NOW(a_stall_when_full, clock, reset, req_stall, pend_ff == 2'd2)
   // A stalled result stays offered.
   `SSRW_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // A stalled result keeps its value.
   `SSRW_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_accepted))

endmodule

bind session_sequence_replay_window_top ssrw_checker #(.SEQ_WIDTH(SEQ_WIDTH)) u_ssrw_checker (.*);

[verif/session_sequence_replay_window_top_tb.sv]
// Self-checking testbench for the session sequence replay window top level.
// Holds its own model of the anti-replay window and depends on ssrw_pkg and the RTL.
module session_sequence_replay_window_top_tb;
   import ssrw_pkg::*;

   localparam int SEQ_W       = SEQ_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 100;
   localparam int PHASE_ITEMS = 215;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [SEQ_W-1:0]          req_sequence_number = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_accepted;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   csr_index_type             csr_index = CSR_WINDOW_SIZE;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   // Numbers waiting to be sent, and verdicts waiting for their result transfer.
   logic [SEQ_W-1:0] number_queue[$];
   bit               verdict_queue[$];

   // Shadow of the window state and of the two registers.
   logic [SEQ_W-1:0]     shadow_highest = '0;
   logic [MAP_WIDTH-1:0] shadow_map = MAP_RESET;
   logic [WIN_WIDTH-1:0] shadow_window = DEFAULT_WINDOW;
   bit                   shadow_v2 = 1'b0;

   logic [SEQ_W-1:0] walk_head;
   bit               steady_flow = 1'b0;
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count = 0;

   session_sequence_replay_window_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sequence_number (req_sequence_number),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
      mismatch_count++;
   endtask

   // Move the highest up by the given distance and record the old highest.
   function automatic void advance_window(logic [SEQ_W-1:0] number, bit [63:0] distance);
      bit [63:0] shifted;
      shifted = {32'd0, shadow_map} << distance;
      shadow_map = shifted[MAP_WIDTH-1:0] | (MAP_ONE << (distance - 1));
      shadow_highest = number;
   endfunction

   // Accept a number behind the highest once, then mark it as seen.
   function automatic bit mark_seen(bit [63:0] distance);
      logic [MAP_WIDTH-1:0] mask;
      if (distance == 0 || distance > MAP_WIDTH) return 1'b0;
      mask = MAP_ONE << (distance - 1);
      if ((shadow_map & mask) != '0) return 1'b0;
      shadow_map = shadow_map | mask;
      return 1'b1;
   endfunction

   // Verdict for one number; updates the shadow state on acceptance.
   function automatic bit replay_check(logic [SEQ_W-1:0] number);
      bit [63:0] num, top_num, high, span, lim, distance;
      bit        v2;
      num     = number;
      top_num = 64'hFFFF_FFFF;
      high    = shadow_highest;
      v2      = shadow_v2;
      if (shadow_window == 0) span = DEFAULT_WINDOW;
      else if (shadow_window > WINDOW_MAX_DEF) span = WINDOW_MAX_DEF;
      else span = shadow_window;

      if (num == high) return 1'b0;
      if (v2 && num == 0) return 1'b0;

      // Ahead of the highest; the window may run past the top of the range.
      if (high > top_num - span) begin
         lim = span - (top_num - high) - 1;
         if (v2) lim++;
         if (num > high || num <= lim) begin
            if (num > high) distance = num - high;
            else distance = num + (top_num - high) + (v2 ? 0 : 1);
            if (distance == 0 || distance > MAP_WIDTH) return 1'b0;
            advance_window(number, distance);
            return 1'b1;
         end
      end else if (num > high && num - high <= span) begin
         advance_window(number, num - high);
         return 1'b1;
      end

      // Behind the highest; the window may run below zero and wrap to the top.
      if (high < span) begin
         lim = top_num - (span - high) + 1;
         if (v2) lim--;
         if (num < high || num >= lim) begin
            if (num > high) distance = high + (top_num - num) + (v2 ? 0 : 1);
            else distance = high - num;
            return mark_seen(distance);
         end
      end else if (num < high && num >= high - span) begin
         return mark_seen(high - num);
      end
      return 1'b0;
   endfunction

   // Request driver: presents queued numbers and predicts each transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            verdict_queue.push_back(replay_check(req_sequence_number));
         end
         if (!req_valid || !req_stall) begin
            if (number_queue.size() != 0 && (steady_flow || $urandom_range(99) >= 20)) begin
               req_valid <= 1'b1;
               req_sequence_number <= number_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each result transfer and stalls at random.
   always @(posedge clock) begin : result_monitor
      bit expected_verdict;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               report_mismatch("result transfer with no verdict outstanding");
            end else begin
               expected_verdict = verdict_queue.pop_front();
               if (rsp_accepted !== expected_verdict) begin
                  report_mismatch($sformatf("accepted is %b, expected %b",
                                            rsp_accepted, expected_verdict));
               end
            end
         end
         rsp_stall <= !steady_flow && ($urandom_range(99) < 20);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[session_sequence_replay_window_top] ERROR");
         $finish;
      end
   end

   // One register write; the shadow copy follows the completed transfer.
   task automatic write_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_WINDOW_SIZE) shadow_window = value;
      else shadow_v2 = value[0];
   endtask

   // Holds off until every number has been sent and every verdict checked.
   task automatic wait_for_drain();
      do @(negedge clock);
      while (number_queue.size() != 0 || req_valid || verdict_queue.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Mostly numbers near the current highest, with some noise and bit flips.
   task automatic load_random(int unsigned count);
      int          offset;
      int unsigned span;
      logic [SEQ_W-1:0] number;
      @(negedge clock);
      if (shadow_window == 0) span = DEFAULT_WINDOW;
      else if (shadow_window > WINDOW_MAX_DEF) span = WINDOW_MAX_DEF;
      else span = shadow_window;
      repeat (count) begin
         case ($urandom_range(99)) inside
            [0:9]: begin
               number = $urandom();
            end
            [10:14]: begin
               number = walk_head ^ (32'h1 << $urandom_range(SEQ_W - 1));
            end
            default: begin
               offset = int'($urandom_range(2 * span + 4)) - int'(span + 2);
               number = walk_head + offset;
               if (offset > 0 && offset <= int'(span)) walk_head = number;
            end
         endcase
         number_queue.push_back(number);
      end
   endtask

   // Stimulus sequencing: directed phases, then random phases over several settings.
   initial begin : stimulus
      logic [CSR_DATA_WIDTH-1:0] window_plan[7] = '{6'd0, 6'd1, 6'd32, 6'd17, 6'd33, 6'd5, 6'd63};
      bit                        mode_plan[7]   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Version 2.0 rules straight from reset: zero, and the top number at distance zero.
      write_register(CSR_PROTOCOL_MODE, 6'd1);
      @(negedge clock);
      number_queue = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFF9, 32'hFFFF_FFF7};
      wait_for_drain();

      // Version 1.5 rules, default window: equal, wrapped duplicates, edges of the window.
      write_register(CSR_PROTOCOL_MODE, 6'd0);
      @(negedge clock);
      number_queue = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF8, 32'hFFFF_FFF7,
                       32'd9, 32'd8, 32'd8, 32'd3, 32'd3};
      wait_for_drain();

      // Oversized window saturates; a full-width advance clears the bitmap.
      write_register(CSR_WINDOW_SIZE, 6'd63);
      write_register(CSR_PROTOCOL_MODE, 6'd1);
      @(negedge clock);
      number_queue = '{32'h0000_0000, 32'd40, 32'd8, 32'd9, 32'd7, 32'd73, 32'd72,
                       32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
      wait_for_drain();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 7; phase++) begin
         write_register(CSR_WINDOW_SIZE, window_plan[phase]);
         write_register(CSR_PROTOCOL_MODE, {5'd0, mode_plan[phase]});
         steady_flow = (phase == 3);
         walk_head = shadow_highest;
         load_random(PHASE_ITEMS / 2);
         // In one phase the sender holds back until every verdict has come back.
         if (phase == 4) wait_for_drain();
         load_random(PHASE_ITEMS - PHASE_ITEMS / 2);
         wait_for_drain();
      end
      steady_flow = 1'b0;

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[session_sequence_replay_window_top] OK");
      end else begin
         $display("[session_sequence_replay_window_top] ERROR");
      end
      $finish;
   end

endmodule
